>>> design/rmvs_pkg.sv
// Shared types and constants for the running mean/variance statistics block.
// Used by the front, queue, back and top-level modules; depends on nothing.
package rmvs_pkg;

  localparam int TIME_BITS_DEF  = 32;
  localparam int COUNT_BITS_DEF = 32;
  localparam int BLOCK_BITS_DEF = 16;

  // Port widths of the payload fields
  localparam int TIME_W  = 32;
  localparam int LINES_W = 16;
  localparam int TOTAL_W = 32;
  localparam int MEAN_W  = 33;
  localparam int VAR_W   = 63;
  localparam int STD_W   = 32;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One classified word handed from front to back
  typedef struct packed {
    logic [TIME_W-1:0]  t;
    logic [LINES_W-1:0] k;
    logic [TOTAL_W-1:0] n;
    logic [TIME_W-1:0]  earliest;
    logic [TIME_W-1:0]  latest;
    logic               ovf;
  } item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_TT,
    ST_KTT,
    ST_KT,
    ST_NX,
    ST_XX,
    ST_NXX,
    ST_SUMX,
    ST_MEAN,
    ST_MM,
    ST_S2,
    ST_VAR,
    ST_SQRT,
    ST_DONE
  } back_state_t;

endpackage

>>> design/rmvs_queue.sv
// Short queue of classified words between the front and the back.
// Depends on rmvs_pkg for item_t and the queue depth (a power of two).
module rmvs_queue
  import rmvs_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output item_t head,
  output logic  full,
  output logic  empty
);

  item_t             slot [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot[wr_ptr] <= push_item;
  end

endmodule

>>> design/rmvs_front.sv
// Front end: takes input words, clamps the line count, tracks total, extremes
// and the sticky overflow, and pushes one classified word. Depends on rmvs_pkg.
module rmvs_front
  import rmvs_pkg::*;
#(
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int BLOCK_BITS = BLOCK_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [TIME_W-1:0]  timestamp,
  input  logic [LINES_W-1:0] line_count,
  input  logic               q_full,
  output logic               push,
  output item_t              push_item
);

  logic [COUNT_BITS-1:0] total;
  logic [TIME_BITS-1:0]  earliest;
  logic [TIME_BITS-1:0]  latest;
  logic                  ovf;

  logic [TIME_BITS-1:0]  t;
  logic [COUNT_BITS-1:0] k_ext;
  logic [COUNT_BITS-1:0] room;
  logic [COUNT_BITS-1:0] k_fit;
  logic                  clamp;
  logic [COUNT_BITS-1:0] total_next;
  logic [TIME_BITS-1:0]  earliest_next;
  logic [TIME_BITS-1:0]  latest_next;
  logic                  ovf_next;

  assign in_ready = !q_full;
  assign push     = in_valid && in_ready;

  always_comb begin
    t             = timestamp[TIME_BITS-1:0];
    k_ext         = COUNT_BITS'(line_count[BLOCK_BITS-1:0]);
    room          = {COUNT_BITS{1'b1}} - total;
    clamp         = (k_ext > room);
    k_fit         = clamp ? room : k_ext;
    total_next    = total + k_fit;
    ovf_next      = ovf || clamp;
    // a stored earliest of zero counts as unset
    earliest_next = ((earliest == '0) || (earliest > t)) ? t : earliest;
    latest_next   = (t > latest) ? t : latest;

    push_item.t        = TIME_W'(t);
    push_item.k        = LINES_W'(k_fit);
    push_item.n        = TOTAL_W'(total_next);
    push_item.earliest = TIME_W'(earliest_next);
    push_item.latest   = TIME_W'(latest_next);
    push_item.ovf      = ovf_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total    <= '0;
      earliest <= '0;
      latest   <= '0;
      ovf      <= 1'b0;
    end else if (push) begin
      total    <= total_next;
      earliest <= earliest_next;
      latest   <= latest_next;
      ovf      <= ovf_next;
    end
  end

endmodule

>>> design/rmvs_back.sv
// Back end: sequencer over a shift-add multiplier, a restoring divider and a
// bit-pair square root; keeps the sums and the result register. Uses rmvs_pkg.
module rmvs_back
  import rmvs_pkg::*;
#(
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int BLOCK_BITS = BLOCK_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [TIME_BITS-1:0] ref_time,
  input  logic                q_empty,
  input  item_t               q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [TOTAL_W-1:0]  total_lines,
  output logic [TIME_W-1:0]   earliest_time,
  output logic [TIME_W-1:0]   latest_time,
  output logic signed [MEAN_W-1:0] mean_value,
  output logic [VAR_W-1:0]    variance_value,
  output logic [STD_W-1:0]    std_deviation,
  output logic                overflow_flag
);

  localparam int SW = COUNT_BITS + TIME_BITS;     // linear sum
  localparam int QW = COUNT_BITS + 2 * TIME_BITS; // sum of squares
  localparam int MW = 2 * SW;                      // square of the linear sum
  localparam int CW = $clog2(MW + 1);

  back_state_t state, state_next;
  logic        phase;

  item_t       it;
  logic [TIME_BITS-1:0]   it_t;
  logic [BLOCK_BITS-1:0]  it_k;
  logic [COUNT_BITS-1:0]  it_n;

  logic [SW-1:0]          time_sum;
  logic [QW-1:0]          sq;
  logic [2*TIME_BITS-1:0] tt;
  logic [SW-1:0]          mag;
  logic                   neg;
  logic [QW-1:0]          qs;
  logic [MEAN_W-1:0]      mean_r;
  logic [VAR_W-1:0]       var_r;
  logic [STD_W-1:0]       std_r;

  // multiplier
  logic [MW-1:0] ma, acc, mac_a, mac_init;
  logic [SW-1:0] mb, mac_b;
  logic          is_mac, mac_done;
  // divider
  logic [MW-1:0]         dq, div_val;
  logic [COUNT_BITS-1:0] rem, dvs, div_dvs;
  logic [CW-1:0]         dcnt, div_cnt;
  logic                  is_div, div_done;
  logic [COUNT_BITS:0]   rem_sh;
  logic                  rem_ge;
  logic [COUNT_BITS:0]   rem_sub;
  // square root
  logic [VAR_W-1:0] sv, sr, sbit;
  logic [VAR_W:0]   s_sum;
  logic             s_ge, sqrt_done;

  logic [SW-1:0]     mean_src;
  logic [MEAN_W-1:0] q33;
  logic              out_free;

  assign it_t = it.t[TIME_BITS-1:0];
  assign it_k = it.k[BLOCK_BITS-1:0];
  assign it_n = it.n[COUNT_BITS-1:0];

  // each unit only reports done while it is the one in use
  assign mac_done  = is_mac && phase && (mb == '0);
  assign div_done  = is_div && phase && (dcnt == '0);
  assign sqrt_done = (state == ST_SQRT) && phase && (sbit == '0);
  assign out_free  = !out_valid || out_ready;
  assign q_pop     = (state == ST_IDLE) && !q_empty;

  assign rem_sh  = {rem, dq[MW-1]};
  assign rem_ge  = (rem_sh >= {1'b0, dvs});
  assign rem_sub = rem_sh - {1'b0, dvs};
  assign s_sum   = {1'b0, sr} + {1'b0, sbit};
  assign s_ge    = ({1'b0, sv} >= s_sum);
  assign mean_src = acc[SW-1:0];
  assign q33      = dq[MEAN_W-1:0];

  always_comb begin
    state_next = state;
    is_mac     = 1'b0;
    is_div     = 1'b0;
    mac_a      = '0;
    mac_b      = '0;
    mac_init   = '0;
    div_val    = '0;
    div_cnt    = '0;
    div_dvs    = '0;
    unique case (state)
      ST_IDLE: if (!q_empty) state_next = ST_TT;
      ST_TT: begin
        is_mac = 1'b1;
        mac_a  = MW'(it_t);
        mac_b  = SW'(it_t);
        if (phase && (mb == '0)) state_next = ST_KTT;
      end
      ST_KTT: begin
        is_mac   = 1'b1;
        mac_a    = MW'(tt);
        mac_b    = SW'(it_k);
        mac_init = MW'(sq);
        if (phase && (mb == '0)) state_next = ST_KT;
      end
      ST_KT: begin
        is_mac   = 1'b1;
        mac_a    = MW'(it_t);
        mac_b    = SW'(it_k);
        mac_init = MW'(time_sum);
        if (phase && (mb == '0)) begin
          if (ref_time != '0) state_next = ST_NX;
          else state_next = (it_n != '0) ? ST_MEAN : ST_DONE;
        end
      end
      ST_NX: begin
        is_mac = 1'b1;
        mac_a  = MW'(ref_time);
        mac_b  = SW'(it_n);
        if (phase && (mb == '0)) state_next = ST_XX;
      end
      ST_XX: begin
        is_mac = 1'b1;
        mac_a  = MW'(ref_time);
        mac_b  = SW'(ref_time);
        if (phase && (mb == '0)) state_next = ST_NXX;
      end
      ST_NXX: begin
        is_mac   = 1'b1;
        mac_a    = MW'(tt);
        mac_b    = SW'(it_n);
        mac_init = MW'(qs);
        if (phase && (mb == '0)) state_next = ST_SUMX;
      end
      ST_SUMX: begin
        is_mac = 1'b1;
        mac_a  = MW'(time_sum);
        mac_b  = SW'({ref_time, 1'b0});
        if (phase && (mb == '0)) state_next = (it_n != '0) ? ST_MEAN : ST_DONE;
      end
      ST_MEAN: begin
        is_div  = 1'b1;
        div_val = {mag, {SW{1'b0}}};
        div_cnt = CW'(SW);
        div_dvs = it_n;
        if (phase && (dcnt == '0)) state_next = (it_n > COUNT_BITS'(1)) ? ST_MM : ST_DONE;
      end
      ST_MM: begin
        is_mac = 1'b1;
        mac_a  = MW'(mag);
        mac_b  = mag;
        if (phase && (mb == '0)) state_next = ST_S2;
      end
      ST_S2: begin
        is_div  = 1'b1;
        div_val = acc;
        div_cnt = CW'(MW);
        div_dvs = it_n;
        if (phase && (dcnt == '0)) state_next = ST_VAR;
      end
      ST_VAR: begin
        is_div  = 1'b1;
        div_val = {qs, {(MW-QW){1'b0}}};
        div_cnt = CW'(QW);
        div_dvs = it_n - COUNT_BITS'(1);
        if (phase && (dcnt == '0)) state_next = ST_SQRT;
      end
      ST_SQRT: if (sqrt_done) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // control and running sums
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= 1'b0;
      time_sum      <= '0;
      sq            <= '0;
      out_valid     <= 1'b0;
      total_lines   <= '0;
      overflow_flag <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (is_mac || is_div || state == ST_SQRT) begin
        if (!phase) phase <= 1'b1;
        else if (mac_done || div_done || sqrt_done) phase <= 1'b0;
      end
      if (mac_done && state == ST_KTT) sq <= acc[QW-1:0];
      if (mac_done && state == ST_KT) time_sum <= acc[SW-1:0];
      if (state == ST_DONE && out_free) begin
        out_valid     <= 1'b1;
        total_lines   <= it.n;
        overflow_flag <= it.ovf;
      end
    end
  end

  // arithmetic units
  always_ff @(posedge clk) begin
    if (is_mac) begin
      if (!phase) begin
        ma  <= mac_a;
        mb  <= mac_b;
        acc <= mac_init;
      end else if (!mac_done) begin
        if (mb[0]) acc <= acc + ma;
        ma <= ma << 1;
        mb <= mb >> 1;
      end
    end
    if (is_div) begin
      if (!phase) begin
        dq   <= div_val;
        dcnt <= div_cnt;
        dvs  <= div_dvs;
        rem  <= '0;
      end else if (!div_done) begin
        rem  <= rem_ge ? rem_sub[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
        dq   <= {dq[MW-2:0], rem_ge};
        dcnt <= dcnt - 1'b1;
      end
    end
    if (state == ST_SQRT) begin
      if (!phase) begin
        sv   <= var_r;
        sr   <= '0;
        sbit <= {1'b1, {(VAR_W-1){1'b0}}};
      end else if (!sqrt_done) begin
        if (s_ge) begin
          sv <= sv - s_sum[VAR_W-1:0];
          sr <= (sr >> 1) + sbit;
        end else begin
          sr <= sr >> 1;
        end
        sbit <= sbit >> 2;
      end
    end
  end

  // per-item datapath
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: if (!q_empty) begin
        it     <= q_item;
        mean_r <= '0;
        var_r  <= '0;
        std_r  <= '0;
      end
      ST_TT: if (mac_done) tt <= acc[2*TIME_BITS-1:0];
      ST_KT: if (mac_done) begin
        mag <= mean_src;
        qs  <= sq;
        neg <= 1'b0;
      end
      ST_NX: if (mac_done) begin
        // age sum is n*ref minus the time sum; track its sign apart
        if (mean_src >= time_sum) begin
          mag <= mean_src - time_sum;
          neg <= 1'b0;
        end else begin
          mag <= time_sum - mean_src;
          neg <= 1'b1;
        end
      end
      ST_XX: if (mac_done) tt <= acc[2*TIME_BITS-1:0];
      ST_NXX: if (mac_done) qs <= acc[QW-1:0];
      ST_SUMX: if (mac_done) qs <= qs - acc[QW-1:0];
      ST_MEAN: if (div_done) mean_r <= neg ? (MEAN_W'(0) - q33) : q33;
      ST_S2: if (div_done) qs <= qs - dq[QW-1:0];
      ST_VAR: if (div_done) var_r <= dq[VAR_W-1:0];
      ST_SQRT: if (sqrt_done) std_r <= sr[STD_W-1:0];
      ST_DONE: if (out_free) begin
        earliest_time  <= it.earliest;
        latest_time    <= it.latest;
        mean_value     <= mean_r;
        variance_value <= var_r;
        std_deviation  <= std_r;
      end
      default: ;
    endcase
  end

endmodule

>>> design/running_mean_variance_stats.sv
// Top level of the running mean/variance statistics block.
// Depends on rmvs_pkg, rmvs_front, rmvs_queue and rmvs_back.
//
// Usage: each input word (timestamp, line_count) is taken on in_valid and
// in_ready. One result word per input leaves on out_valid and out_ready:
// running total, earliest and latest time, truncated mean, truncated sample
// variance, its floor square root and a sticky overflow flag.
// reference_time is written through cfg_write_en/cfg_write_data; the user is
// to write it only while idle, which the block itself does not enforce. When
// nonzero, mean and variance are taken over ages (reference minus t).
// The front updates the count and extremes in the cycle it takes a word and
// queues it (two words deep). The back works one word at a time through a
// one-bit-per-cycle shift-add multiplier, a restoring divider and a
// bit-pair square root; the 128-step division of the squared sum takes the
// largest share of an item's time.
// When the receiver stalls the finished result holds in the output register;
// the front keeps taking words until the queue fills.
// Reset (synchronous) clears all sums, extremes, the flag and out_valid.
module running_mean_variance_stats
  import rmvs_pkg::*;
#(
  parameter int TIME_BITS  = TIME_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int BLOCK_BITS = BLOCK_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write_en,
  input  logic [TIME_W-1:0]        cfg_write_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [TIME_W-1:0]        timestamp,
  input  logic [LINES_W-1:0]       line_count,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [TOTAL_W-1:0]       total_lines,
  output logic [TIME_W-1:0]        earliest_time,
  output logic [TIME_W-1:0]        latest_time,
  output logic signed [MEAN_W-1:0] mean_value,
  output logic [VAR_W-1:0]         variance_value,
  output logic [STD_W-1:0]         std_deviation,
  output logic                     overflow_flag
);

  logic [TIME_W-1:0] reference_time;
  logic              q_full, q_empty, push, pop;
  item_t             push_item, head;

  always_ff @(posedge clk) begin
    if (rst) reference_time <= '0;
    else if (cfg_write_en) reference_time <= cfg_write_data;
  end

  rmvs_front #(
    .TIME_BITS (TIME_BITS),
    .COUNT_BITS(COUNT_BITS),
    .BLOCK_BITS(BLOCK_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .timestamp (timestamp),
    .line_count(line_count),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  rmvs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(push_item),
    .pop      (pop),
    .head     (head),
    .full     (q_full),
    .empty    (q_empty)
  );

  rmvs_back #(
    .TIME_BITS (TIME_BITS),
    .COUNT_BITS(COUNT_BITS),
    .BLOCK_BITS(BLOCK_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .ref_time      (reference_time[TIME_BITS-1:0]),
    .q_empty       (q_empty),
    .q_item        (head),
    .q_pop         (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .total_lines   (total_lines),
    .earliest_time (earliest_time),
    .latest_time   (latest_time),
    .mean_value    (mean_value),
    .variance_value(variance_value),
    .std_deviation (std_deviation),
    .overflow_flag (overflow_flag)
  );

  // overflow is sticky until reset
  a_ovf_sticky: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> !$fell(overflow_flag))
    else $error("overflow flag cleared without reset");

  a_total_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (total_lines >= $past(total_lines)))
    else $error("line total went down");

  a_var_few_lines: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (total_lines < TOTAL_W'(2))) |->
      ((variance_value == '0) && (std_deviation == '0)))
    else $error("variance nonzero with fewer than two lines");

endmodule

>>> tb/sv/tb_top.sv
// Testbench for running_mean_variance_stats: drives (timestamp, line_count) words with
// bursty valid and a stalling receiver, and checks each result against a local predictor.
// Depends on rmvs_pkg and the design files only.
module tb_top;
  import rmvs_pkg::*;

  typedef struct {
    logic [TOTAL_W-1:0]       total;
    logic [TIME_W-1:0]        earliest;
    logic [TIME_W-1:0]        latest;
    logic signed [MEAN_W-1:0] mean;
    logic [VAR_W-1:0]         variance;
    logic [STD_W-1:0]         stdev;
    logic                     ovf;
  } stats_t;

  localparam logic [63:0] COUNT_MAX = 64'h0000_0000_FFFF_FFFF;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [TIME_W-1:0] cfg_write_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [TIME_W-1:0] timestamp = '0;
  logic [LINES_W-1:0] line_count = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [TOTAL_W-1:0] total_lines;
  logic [TIME_W-1:0] earliest_time;
  logic [TIME_W-1:0] latest_time;
  logic signed [MEAN_W-1:0] mean_value;
  logic [VAR_W-1:0] variance_value;
  logic [STD_W-1:0] std_deviation;
  logic overflow_flag;

  // predictor state
  logic [31:0]  age_origin = '0;
  logic [63:0]  lines_acc = '0;
  logic [63:0]  time_acc = '0;
  logic [127:0] square_acc = '0;
  logic [31:0]  first_seen = '0;
  logic [31:0]  last_seen = '0;
  logic         saturated = 1'b0;

  stats_t expected_stats[$];
  int mismatches = 0;
  int burst_left = 0;

  always #4 clk = ~clk;

  running_mean_variance_stats DUT (
    .clk(clk), .rst(rst),
    .cfg_write_en(cfg_write_en), .cfg_write_data(cfg_write_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .timestamp(timestamp), .line_count(line_count),
    .out_valid(out_valid), .out_ready(out_ready),
    .total_lines(total_lines), .earliest_time(earliest_time), .latest_time(latest_time),
    .mean_value(mean_value), .variance_value(variance_value),
    .std_deviation(std_deviation), .overflow_flag(overflow_flag)
  );

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] bitpos;
    root = '0;
    bitpos = 64'd1 << 62;
    while (bitpos > v) bitpos = bitpos >> 2;
    while (bitpos != 0) begin
      if (v >= root + bitpos) begin
        v = v - (root + bitpos);
        root = (root >> 1) + bitpos;
      end else begin
        root = root >> 1;
      end
      bitpos = bitpos >> 2;
    end
    return root;
  endfunction

  // advance the accumulators by one word and return the statistics it yields
  function automatic stats_t predict_stats(input logic [31:0] t, input logic [15:0] lc);
    stats_t r;
    logic [63:0]  k;
    logic [63:0]  room;
    logic [63:0]  x;
    logic [63:0]  mag;
    logic [63:0]  avg;
    logic [127:0] qs;
    logic [127:0] s2;
    logic [127:0] v;
    logic [62:0]  var_trunc;
    logic         neg;
    k = {48'd0, lc};
    x = {32'd0, age_origin};
    room = COUNT_MAX - lines_acc;
    if (k > room) begin
      k = room;
      saturated = 1'b1;
    end
    lines_acc = lines_acc + k;
    time_acc = time_acc + k * {32'd0, t};
    square_acc = square_acc + {64'd0, k} * {64'd0, {32'd0, t} * {32'd0, t}};
    if (first_seen == 0 || first_seen > t) first_seen = t;
    if (t > last_seen) last_seen = t;
    mag = time_acc;
    qs = square_acc;
    neg = 1'b0;
    if (x != 0) begin
      if (lines_acc * x >= time_acc) mag = lines_acc * x - time_acc;
      else begin
        mag = time_acc - lines_acc * x;
        neg = 1'b1;
      end
      qs = qs + {64'd0, lines_acc} * {64'd0, x * x};
      qs = qs - {64'd0, 2 * x} * {64'd0, time_acc};
    end
    avg = '0;
    var_trunc = '0;
    if (lines_acc > 0) avg = mag / lines_acc;
    if (lines_acc > 1) begin
      s2 = ({64'd0, mag} * {64'd0, mag}) / {64'd0, lines_acc};
      v = (qs - s2) / {64'd0, lines_acc - 1};
      var_trunc = v[62:0];
    end
    r.total = lines_acc[31:0];
    r.earliest = first_seen;
    r.latest = last_seen;
    r.mean = neg ? (33'd0 - avg[32:0]) : avg[32:0];
    r.variance = var_trunc;
    r.stdev = (var_trunc != 0) ? STD_W'(floor_sqrt({1'b0, var_trunc})) : '0;
    r.ovf = saturated;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("tb: mismatch on %s: got %h, expected %h", field, got, want);
    mismatches++;
  endtask

  // compare each accepted result word with the oldest expectation
  always @(posedge clk) begin
    stats_t e;
    if (!rst && out_valid && out_ready) begin
      if (expected_stats.size() == 0) begin
        report_mismatch("unexpected word", {32'd0, total_lines}, 64'd0);
      end else begin
        e = expected_stats.pop_front();
        if (total_lines !== e.total)
          report_mismatch("total_lines", 64'(total_lines), 64'(e.total));
        if (earliest_time !== e.earliest)
          report_mismatch("earliest_time", 64'(earliest_time), 64'(e.earliest));
        if (latest_time !== e.latest)
          report_mismatch("latest_time", 64'(latest_time), 64'(e.latest));
        if (mean_value !== e.mean)
          report_mismatch("mean_value", 64'(mean_value), 64'(e.mean));
        if (variance_value !== e.variance)
          report_mismatch("variance_value", 64'(variance_value), 64'(e.variance));
        if (std_deviation !== e.stdev)
          report_mismatch("std_deviation", 64'(std_deviation), 64'(e.stdev));
        if (overflow_flag !== e.ovf)
          report_mismatch("overflow_flag", 64'(overflow_flag), 64'(e.ovf));
      end
    end
  end

  // receiver: stretches of always-ready, of mostly-stalled and of random ready
  initial begin
    int mode;
    int len;
    forever begin
      mode = $urandom_range(0, 2);
      len = $urandom_range(1, 400);
      repeat (len) begin
        @(negedge clk);
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // entered and left at a falling edge
  task automatic send_word(input logic [31:0] t, input logic [15:0] lc);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    timestamp <= t;
    line_count <= lc;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    expected_stats.push_back(predict_stats(t, lc));
    @(negedge clk);
  endtask

  // write the reference time once every result has drained
  task automatic write_reference(input logic [31:0] value);
    in_valid <= 1'b0;
    while (expected_stats.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_write_en <= 1'b1;
    cfg_write_data <= value;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    age_origin = value;
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_time();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(1, 16);
      3: return 32'h6000_0000 + $urandom_range(0, 100000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_count();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'd1;
      3: return 16'($urandom_range(2, 20));
      default: return 16'($urandom_range(0, 16'hFFFF));
    endcase
  endfunction

  task automatic test_raw_extremes();
    send_word(32'd0, 16'd0);          // empty block, earliest unset
    send_word(32'd0, 16'd1);          // a zero timestamp leaves earliest unset
    send_word(32'd1000, 16'd1);       // a second line: mean and variance over two lines
    send_word(32'd1000, 16'd1);       // a third line, equal to the second
    send_word(32'd500, 16'd0);        // empty block still moves earliest
    send_word(32'hFFFF_FFFF, 16'hFFFF);
    send_word(32'd1, 16'hFFFF);
    send_word(32'hFFFF_FFFF, 16'd1);
    send_word(32'h5555_5555, 16'h5555);
    send_word(32'hAAAA_AAAA, 16'hAAAA);
  endtask

  task automatic test_reference_ages();
    write_reference(32'hFFFF_FFFF);   // every age non-negative
    send_word(32'd0, 16'd3);
    send_word(32'hFFFF_FFFF, 16'd2);
    send_word(32'h8000_0000, 16'd0);
    write_reference(32'd1);           // most ages negative
    send_word(32'h1234_5678, 16'd7);
    send_word(32'd1, 16'd1);
    write_reference(32'h8000_0000);
    send_word(32'h7FFF_FFFF, 16'hFFFF);
    send_word(32'h8000_0001, 16'hFFFF);
  endtask

  task automatic test_random_words();
    logic [31:0] ref_choices[4];
    ref_choices = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'd0};
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 5) write_reference(32'd0);
      else if (phase > 0)
        write_reference(($urandom_range(0, 1) == 0) ? ref_choices[phase % 4] : $urandom);
      repeat (90) send_word(pick_time(), pick_count());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_raw_extremes();
    test_reference_ages();
    test_random_words();
    in_valid <= 1'b0;
    while (expected_stats.size() != 0) @(posedge clk);
    repeat (700) @(posedge clk);
    if (mismatches == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #40000000;
    $display("tb: failure");
    $finish;
  end

endmodule

>>> sim.f
design/rmvs_pkg.sv
design/rmvs_queue.sv
design/rmvs_front.sv
design/rmvs_back.sv
design/running_mean_variance_stats.sv
tb/sv/tb_top.sv
